>>> hw/rtl/huffman_bitstream_packer_defines.svh
// Assertion macros used by the checker file.
`ifndef HUFFMAN_BITSTREAM_PACKER_DEFINES_SVH
`define HUFFMAN_BITSTREAM_PACKER_DEFINES_SVH

// General property, clocked on clk_i and disabled while rst_ni is low.
`define HBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Signal must stay unchanged in the cycle after a stalled transfer.
`define HBP_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> $stable(sig)) else $error(msg);

`endif

>>> hw/rtl/hbp_pkg.sv
package hbp_pkg;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned SymW    = 8;
  localparam int unsigned WordW   = 32;
  localparam int unsigned LenInW  = 6;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PadW    = 3;
  localparam int unsigned PendW   = 7;

  localparam int unsigned DefMaxCodeLen   = 32;
  localparam int unsigned DefAlphabetSize = 256;
  localparam int unsigned QueueDepth      = 4;

  typedef enum logic [CmdW-1:0] {
    CmdLoad   = 2'd0,
    CmdEncode = 2'd1,
    CmdFlush  = 2'd2
  } cmd_e;

  // Stored code width: the loaded length saturates at the smaller of the two.
  function automatic int unsigned code_width(input int unsigned max_len);
    return (max_len < WordW) ? max_len : WordW;
  endfunction

  function automatic int unsigned len_width(input int unsigned max_len);
    return $clog2(code_width(max_len) + 1);
  endfunction

endpackage

>>> hw/rtl/hbp_if.sv
interface hbp_in_if;
  import hbp_pkg::*;

  logic                valid;
  logic                ready;
  logic [CmdW-1:0]     command;
  logic [SymW-1:0]     symbol;
  logic [WordW-1:0]    code_word;
  logic [LenInW-1:0]   code_length;

  modport source (output valid, command, symbol, code_word, code_length, input ready);
  modport sink   (input valid, command, symbol, code_word, code_length, output ready);
endinterface

interface hbp_out_if;
  import hbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  out_byte;
  logic              last_of_run;
  logic              final_byte;
  logic [PadW-1:0]   pad_bits;

  modport source (output valid, out_byte, last_of_run, final_byte, pad_bits, input ready);
  modport sink   (input valid, out_byte, last_of_run, final_byte, pad_bits, output ready);
endinterface

>>> hw/rtl/huffman_bitstream_packer.sv
// Table-driven Huffman packer for byte symbols.
// in_i  : command words (load table row, encode symbol, flush); valid/ready.
// out_o : packed bytes, earliest code bit in bit 7, with last_of_run,
//         final_byte and pad_bits; valid/ready, held while out_o.ready is low.
// An encode word that yields a byte passes the table read, classify into
// queue, merge and the byte register, in that order.
// Throughput: while the receiver is ready, the bit packer merges one code
// per cycle and sends one byte per cycle; an encode word that completes
// bytes holds it until under eight bits remain, worst for a full-length code
// on seven pending bits. Words that make no byte also go at one per cycle.
// Loads, encodes of unloaded or out-of-range symbols and unused commands
// are dropped in the front end and never reach the packer.
// Reset clears the loaded flags of the table at once (every symbol reads as
// unloaded), empties the queue and the pending bits; no clearing pass.
// When the receiver stalls, the output register holds, the packer stops at
// its next byte, the queue fills and in_i.ready then drops.
module huffman_bitstream_packer #(
  parameter int unsigned MAX_CODE_LEN  = hbp_pkg::DefMaxCodeLen,
  parameter int unsigned ALPHABET_SIZE = hbp_pkg::DefAlphabetSize
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hbp_in_if.sink     in_i,
  hbp_out_if.source  out_o
);
  import hbp_pkg::*;

  // Queue word: flush flag, code length, masked code bits.
  localparam int unsigned EntryW = 1 + len_width(MAX_CODE_LEN) + code_width(MAX_CODE_LEN);

  logic              push_valid, push_ready, pop_valid, pop_ready;
  logic [EntryW-1:0] push_data, pop_data;

  // Front end: accept, look up the table, drop words that carry no code or flush.
  hbp_front #(
    .MaxCodeLen   (MAX_CODE_LEN),
    .AlphabetSize (ALPHABET_SIZE),
    .EntryW       (EntryW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Short queue so the front end keeps taking words while bytes drain.
  hbp_fifo #(
    .Width (EntryW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Back end: bit accumulator, one byte per cycle into the output register while it is free.
  hbp_back #(
    .MaxCodeLen (MAX_CODE_LEN),
    .EntryW     (EntryW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

endmodule

>>> hw/rtl/hbp_fifo.sv
module hbp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] slot_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hw/rtl/hbp_front.sv
module hbp_front #(
  parameter int unsigned MaxCodeLen   = hbp_pkg::DefMaxCodeLen,
  parameter int unsigned AlphabetSize = hbp_pkg::DefAlphabetSize,
  parameter int unsigned EntryW       = 1 + hbp_pkg::len_width(MaxCodeLen)
                                          + hbp_pkg::code_width(MaxCodeLen)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  hbp_in_if.sink            in_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output logic [EntryW-1:0] push_data_o
);
  import hbp_pkg::*;

  localparam int unsigned CodeW   = code_width(MaxCodeLen);
  localparam int unsigned LenW    = len_width(MaxCodeLen);
  localparam int unsigned TblAw   = $clog2(AlphabetSize);
  localparam int unsigned SymCmpW = SymW + 1;

  // Table memory: length and masked code per symbol; flags mark loaded rows.
  logic [LenW+CodeW-1:0]  tbl_mem_q [AlphabetSize];
  logic [AlphabetSize-1:0] tbl_vld_q;

  cmd_e             cmd;
  logic             accept, in_range, wr_en;
  logic [TblAw-1:0] idx;
  logic [LenW-1:0]  len_sat;
  logic [CodeW-1:0] code_mask, code_ld;

  logic                  s1_valid_q;
  cmd_e                  s1_cmd_q;
  logic                  s1_hit_q;
  logic [LenW+CodeW-1:0] s1_row_q;
  logic [LenW-1:0]       s1_len;
  logic                  push_enc, push_flush, s1_need, s1_adv;

  assign cmd      = cmd_e'(in_i.command);
  assign accept   = in_i.valid && in_i.ready;
  assign in_range = {1'b0, in_i.symbol} < SymCmpW'(AlphabetSize);
  assign idx      = in_i.symbol[TblAw-1:0];
  assign wr_en    = accept && (cmd == CmdLoad) && in_range;

  // Saturate over-long codes and keep only the valid low code bits.
  assign len_sat   = (in_i.code_length > LenInW'(CodeW)) ? LenW'(CodeW)
                                                         : in_i.code_length[LenW-1:0];
  assign code_mask = (len_sat >= LenW'(CodeW)) ? {CodeW{1'b1}}
                                               : ((CodeW'(1) << len_sat) - CodeW'(1));
  assign code_ld   = in_i.code_word[CodeW-1:0] & code_mask;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_mem_q[idx] <= {len_sat, code_ld};
    end
    if (accept && in_range) begin
      s1_row_q <= tbl_mem_q[idx];
    end
    if (accept) begin
      s1_cmd_q <= cmd;
      s1_hit_q <= in_range && tbl_vld_q[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_vld_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        tbl_vld_q[idx] <= 1'b1;
      end
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
    end
  end

  // Classify: loads, unknown commands, table misses and empty codes are dropped here.
  assign s1_len     = s1_row_q[LenW+CodeW-1:CodeW];
  assign push_enc   = (s1_cmd_q == CmdEncode) && s1_hit_q && (s1_len != '0);
  assign push_flush = (s1_cmd_q == CmdFlush);
  assign s1_need    = s1_valid_q && (push_enc || push_flush);
  assign s1_adv     = !s1_need || push_ready_i;

  assign in_i.ready   = !s1_valid_q || s1_adv;
  assign push_valid_o = s1_need;
  assign push_data_o  = {push_flush, s1_row_q};

endmodule

>>> hw/rtl/hbp_back.sv
module hbp_back #(
  parameter int unsigned MaxCodeLen = hbp_pkg::DefMaxCodeLen,
  parameter int unsigned EntryW     = 1 + hbp_pkg::len_width(MaxCodeLen)
                                        + hbp_pkg::code_width(MaxCodeLen)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  logic [EntryW-1:0] pop_data_i,
  hbp_out_if.source         out_o
);
  import hbp_pkg::*;

  localparam int unsigned CodeW = code_width(MaxCodeLen);
  localparam int unsigned LenW  = len_width(MaxCodeLen);
  localparam int unsigned AccW  = CodeW + PendW;
  localparam int unsigned CntW  = $clog2(AccW + 1);

  logic             head_flush;
  logic [LenW-1:0]  head_len;
  logic [CodeW-1:0] head_code;

  logic [AccW-1:0]  acc_q, acc_d, merged_acc, acc_shr;
  logic [CntW-1:0]  cnt_q, cnt_d, rem, base, merged_cnt;
  logic             out_free, full_byte, emit_data, merge_ok;
  logic [ByteW-1:0] one_sh, pend_mask, fl_byte;
  logic [PendW-1:0] pend;
  logic [PadW-1:0]  fl_pad;

  logic             out_vld_q, out_vld_d, load_out;
  logic [ByteW-1:0] byte_q, byte_d;
  logic             last_q, last_d, fin_q, fin_d;
  logic [PadW-1:0]  pad_q, pad_d;

  assign head_flush = pop_data_i[EntryW-1];
  assign head_len   = pop_data_i[CodeW +: LenW];
  assign head_code  = pop_data_i[CodeW-1:0];

  assign out_free   = !out_vld_q || out_o.ready;
  assign full_byte  = cnt_q >= CntW'(8);
  assign rem        = cnt_q - CntW'(8);
  assign emit_data  = full_byte && out_free;
  assign base       = emit_data ? rem : cnt_q;
  // Next code may join once fewer than eight bits remain after this byte.
  assign merge_ok   = !full_byte || (emit_data && (rem < CntW'(8)));

  assign one_sh     = ByteW'(1) << base[2:0];
  assign pend_mask  = one_sh - ByteW'(1);
  assign pend       = acc_q[PendW-1:0] & pend_mask[PendW-1:0];
  assign merged_acc = (AccW'(pend) << head_len) | AccW'(head_code);
  assign merged_cnt = base + CntW'(head_len);

  assign acc_shr    = acc_q >> rem;
  assign fl_pad     = PadW'(4'd8 - {1'b0, cnt_q[2:0]});
  assign fl_byte    = ByteW'(pend) << fl_pad;

  always_comb begin
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    pop_ready_o = 1'b0;
    load_out    = 1'b0;
    byte_d      = byte_q;
    last_d      = last_q;
    fin_d       = fin_q;
    pad_d       = pad_q;

    if (emit_data) begin
      load_out = 1'b1;
      byte_d   = acc_shr[ByteW-1:0];
      last_d   = rem < CntW'(8);
      fin_d    = 1'b0;
      pad_d    = '0;
      cnt_d    = rem;
    end

    if (merge_ok && pop_valid_i && !head_flush) begin
      pop_ready_o = 1'b1;
      acc_d       = merged_acc;
      cnt_d       = merged_cnt;
    end else if (!full_byte && pop_valid_i && head_flush) begin
      if (cnt_q == '0) begin
        pop_ready_o = 1'b1;
      end else if (out_free) begin
        pop_ready_o = 1'b1;
        load_out    = 1'b1;
        byte_d      = fl_byte;
        last_d      = 1'b1;
        fin_d       = 1'b1;
        pad_d       = fl_pad;
        cnt_d       = '0;
      end
    end

    if (load_out) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    byte_q <= byte_d;
    last_q <= last_d;
    fin_q  <= fin_d;
    pad_q  <= pad_d;
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.out_byte    = byte_q;
  assign out_o.last_of_run = last_q;
  assign out_o.final_byte  = fin_q;
  assign out_o.pad_bits    = pad_q;

endmodule

>>> hw/rtl/hbp_checker.sv
`include "huffman_bitstream_packer_defines.svh"

module hbp_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [hbp_pkg::ByteW-1:0] out_byte_i,
  input logic                     last_of_run_i,
  input logic                     final_byte_i,
  input logic [hbp_pkg::PadW-1:0]  pad_bits_i
);
  import hbp_pkg::*;

  logic [ByteW+PadW+1:0] payload;

  assign payload = {out_byte_i, last_of_run_i, final_byte_i, pad_bits_i};

  `HBP_ASSERT_HOLD(a_out_valid_hold, out_valid_i, out_ready_i, out_valid_i, "out valid dropped")
  `HBP_ASSERT_HOLD(a_out_word_hold, out_valid_i, out_ready_i, payload, "out word changed")
  `HBP_ASSERT(a_final_is_last, (out_valid_i && final_byte_i) |-> last_of_run_i, "flush byte not last")
  `HBP_ASSERT(a_pad_only_flush, (out_valid_i && !final_byte_i) |-> (pad_bits_i == '0), "pad on data byte")
  `HBP_ASSERT(a_flush_pad_set, (out_valid_i && final_byte_i) |-> (pad_bits_i != '0), "flush without pad")

endmodule

bind huffman_bitstream_packer hbp_checker u_hbp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_byte_i    (out_o.out_byte),
  .last_of_run_i (out_o.last_of_run),
  .final_byte_i  (out_o.final_byte),
  .pad_bits_i    (out_o.pad_bits)
);
